// File: rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types for the sliding-window median filter
// Item kinds, the control bundle broadcast along the cell chain and the
// per-cell compare flags handed to neighbours.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int unsigned DATA_W = 16;

    typedef enum logic [0:0] {
        KIND_SAMPLE = 1'b0,
        KIND_PRESET = 1'b1
    } kind_t;

    typedef struct packed {
        logic              push;
        logic              preset;
        logic [DATA_W-1:0] sample;
        logic [DATA_W-1:0] oldest;
    } swm_ctl_t;

    typedef struct packed {
        logic lt_rem;
        logic is_rem;
        logic ge_new;
    } swm_flags_t;

endpackage

// File: rtl/core/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds a value and its age; on a push it keeps its entry, takes a neighbour's
// entry or the new sample, keeping the row sorted; a preset loads the sample.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int unsigned WINDOW = 16,
    parameter int unsigned INDEX  = 0,
    parameter int unsigned AW     = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  swm_pkg::swm_ctl_t              ctl,
    input  logic [swm_pkg::DATA_W-1:0]     left_value,
    input  logic [AW-1:0]                  left_age,
    input  swm_pkg::swm_flags_t            left_flags,
    input  logic [swm_pkg::DATA_W-1:0]     right_value,
    input  logic [AW-1:0]                  right_age,
    input  swm_pkg::swm_flags_t            right_flags,
    output logic [swm_pkg::DATA_W-1:0]     value,
    output logic [AW-1:0]                  age,
    output swm_pkg::swm_flags_t            flags
);

    localparam logic HAS_LEFT  = (INDEX > 0);
    localparam logic HAS_RIGHT = (INDEX + 1 < WINDOW);
    localparam logic [AW-1:0] AGE_MAX  = AW'(WINDOW - 1);
    localparam logic [AW-1:0] AGE_HOME = AW'(INDEX);

    logic [swm_pkg::DATA_W-1:0] value_reg, value_next;
    logic [AW-1:0]              age_reg, age_next;
    logic                       from_right, from_left, keep;

    assign flags.is_rem = (age_reg == AGE_MAX);
    assign flags.lt_rem = $signed(ctl.oldest) < $signed(value_reg);
    assign flags.ge_new = $signed(ctl.sample) <= $signed(value_reg);

    assign from_right = HAS_RIGHT && right_flags.lt_rem && !right_flags.ge_new;
    assign from_left  = HAS_LEFT && !left_flags.lt_rem && !left_flags.is_rem
                        && left_flags.ge_new;
    assign keep       = (flags.lt_rem && flags.ge_new)
                        || (!flags.lt_rem && !flags.is_rem && !flags.ge_new);

    always_comb begin
        value_next = value_reg;
        age_next   = age_reg;
        if (ctl.preset) begin
            value_next = ctl.sample;
            age_next   = AGE_HOME;
        end else if (ctl.push) begin
            if (from_right) begin
                value_next = right_value;
                age_next   = right_age + 1'b1;
            end else if (from_left) begin
                value_next = left_value;
                age_next   = left_age + 1'b1;
            end else if (keep) begin
                age_next   = age_reg + 1'b1;
            end else begin
                value_next = ctl.sample;
                age_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            age_reg   <= AGE_HOME;
        end else begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule

// File: rtl/core/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median: running median over the last WINDOW samples
// The result is valid in the cycle after the input transfer.
// One item per cycle unless m_ready stalls; the sorted row updates in one step.
// The result port reads the middle cell directly while the output is held.
// Reset: window cleared to zeros, output empty.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int unsigned WINDOW = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic signed [swm_pkg::DATA_W-1:0] s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [swm_pkg::DATA_W-1:0] m_median_value
);

    localparam int unsigned AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned MID = WINDOW / 2;

    logic [swm_pkg::DATA_W-1:0] cell_value [WINDOW];
    logic [AW-1:0]              cell_age   [WINDOW];
    swm_pkg::swm_flags_t        cell_flags [WINDOW];
    logic [WINDOW-1:0]          rem_vec;
    logic [WINDOW-1:0]          sorted_vec;
    logic [swm_pkg::DATA_W-1:0] oldest;
    swm_pkg::swm_ctl_t          ctl;
    logic                       m_valid_reg, m_valid_next;
    logic                       accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        oldest = '0;
        for (int i = 0; i < WINDOW; i++) begin
            rem_vec[i] = cell_flags[i].is_rem;
            oldest     = oldest | (cell_flags[i].is_rem ? cell_value[i] : '0);
        end
    end

    assign ctl.push   = accept && (s_kind == swm_pkg::KIND_SAMPLE);
    assign ctl.preset = accept && (s_kind == swm_pkg::KIND_PRESET);
    assign ctl.sample = s_sample;
    assign ctl.oldest = oldest;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        localparam int unsigned LI = (g > 0) ? g - 1 : 0;
        localparam int unsigned RI = (g + 1 < WINDOW) ? g + 1 : g;

        swm_cell #(
            .WINDOW (WINDOW),
            .INDEX  (g),
            .AW     (AW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .left_value  (cell_value[LI]),
            .left_age    (cell_age[LI]),
            .left_flags  (cell_flags[LI]),
            .right_value (cell_value[RI]),
            .right_age   (cell_age[RI]),
            .right_flags (cell_flags[RI]),
            .value       (cell_value[g]),
            .age         (cell_age[g]),
            .flags       (cell_flags[g])
        );

        assign sorted_vec[g] = (g + 1 < WINDOW)
            ? ($signed(cell_value[g]) <= $signed(cell_value[RI])) : 1'b1;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median_value = $signed(cell_value[MID]);

    a_one_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(rem_vec))
        else $error("window must hold exactly one oldest entry");

    a_row_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        &sorted_vec)
        else $error("cell row out of order");

    a_preset_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(accept) && $past(s_kind == swm_pkg::KIND_PRESET)
        |-> m_median_value == $past(s_sample))
        else $error("preset result differs from fill value");

endmodule
